### hw/rtl/orff_pkg.sv
// Shared types and constants of the open reading frame finder.
package orff_pkg;

   // Reset values of the codon masks: ATG start; TAA, TAG and TGA stop.
   localparam logic [63:0] START_MASK_RESET = 64'd16384;
   localparam logic [63:0] STOP_MASK_RESET  = 64'd73464968921481216;

   // Configuration register indexes.
   localparam logic CSR_START_MASK = 1'b0;
   localparam logic CSR_STOP_MASK  = 1'b1;

   // Number of frames and entries of the command queue.
   localparam int FRAME_COUNT = 3;
   localparam int QUEUE_DEPTH = 4;

   // What the front end asks the back end to do with one codon.
   typedef enum logic [1:0] {
      CMD_NONE  = 2'd0,
      CMD_START = 2'd1,
      CMD_STOP  = 2'd2
   } cmd_kind_type;

   // Control part of one command; the position travels beside it.
   typedef struct packed {
      cmd_kind_type kind;
      logic [1:0]   frame;
      logic         clear;
   } cmd_ctl_type;

   // Back end sequencer states.
   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_READ = 3'b010,
      S_SHOW = 3'b100
   } back_state_type;

endpackage

### hw/rtl/orff_front.sv
// Front end: takes bases, forms codons and classifies them into commands.
module orff_front
   import orff_pkg::*;
#(
   parameter int POSITION_WIDTH = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [1:0]                req_base,
   input  logic                      req_last_base,
   input  logic                      csr_write_enable,
   input  logic                      csr_index,
   input  logic [63:0]               csr_write_data,
   output logic                      cmd_valid,
   input  logic                      cmd_ready,
   output cmd_ctl_type               cmd_ctl,
   output logic [POSITION_WIDTH-1:0] cmd_pos
);

   logic [3:0]                window_ff;
   logic [POSITION_WIDTH-1:0] pos_ff;
   logic [1:0]                frame_ff;
   logic [1:0]                fill_ff;
   logic [63:0]               start_mask_ff;
   logic [63:0]               stop_mask_ff;

   logic [5:0]   codon;
   logic [1:0]   frame_next;
   logic         codon_ok;
   logic         accept;
   cmd_kind_type kind;

   // A base is taken whenever the queue has room for its command.
   assign req_ready = cmd_ready;
   assign accept    = req_valid && req_ready;

   // Codon of the two held bases and the new one, and the frame of its start.
   always_comb begin
      codon    = {window_ff, req_base};
      codon_ok = (fill_ff == 2'd2);
      case (frame_ff)
         2'd0:    frame_next = 2'd1;
         2'd1:    frame_next = 2'd2;
         default: frame_next = 2'd0;
      endcase
   end

   // Classification; a start takes precedence over a stop.
   always_comb begin
      if (codon_ok && start_mask_ff[codon]) begin
         kind = CMD_START;
      end else if (codon_ok && stop_mask_ff[codon]) begin
         kind = CMD_STOP;
      end else begin
         kind = CMD_NONE;
      end
   end

   // A command goes out for every start or stop codon and for the last base.
   always_comb begin
      cmd_valid     = accept && ((kind != CMD_NONE) || req_last_base);
      cmd_ctl.kind  = kind;
      cmd_ctl.frame = frame_next;
      cmd_ctl.clear = req_last_base;
      cmd_pos       = (kind == CMD_START) ? (pos_ff - POSITION_WIDTH'(2)) : pos_ff;
   end

   // Window, position and frame tracking; the last base returns all to zero.
   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= '0;
         pos_ff    <= '0;
         frame_ff  <= '0;
         fill_ff   <= '0;
      end else if (accept) begin
         if (req_last_base) begin
            window_ff <= '0;
            pos_ff    <= '0;
            frame_ff  <= '0;
            fill_ff   <= '0;
         end else begin
            window_ff <= {window_ff[1:0], req_base};
            pos_ff    <= pos_ff + POSITION_WIDTH'(1);
            frame_ff  <= frame_next;
            if (fill_ff != 2'd2) begin
               fill_ff <= fill_ff + 2'd1;
            end
         end
      end
   end

   // Codon mask registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         start_mask_ff <= START_MASK_RESET;
         stop_mask_ff  <= STOP_MASK_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_START_MASK: start_mask_ff <= csr_write_data;
            CSR_STOP_MASK:  stop_mask_ff  <= csr_write_data;
            default:        ;
         endcase
      end
   end

endmodule

### hw/rtl/orff_queue.sv
// Short command queue between the front end and the back end.
module orff_queue
   import orff_pkg::*;
#(
   parameter int WIDTH = 37
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [WIDTH-1:0] in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [WIDTH-1:0] out_data
);

   localparam int PW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [0:QUEUE_DEPTH-1];
   logic [PW-1:0]    wr_ptr_ff;
   logic [PW-1:0]    rd_ptr_ff;
   logic [CW-1:0]    count_ff;
   logic             push;
   logic             pop;

   always_comb begin
      in_ready  = (count_ff != CW'(QUEUE_DEPTH));
      out_valid = (count_ff != '0);
      push      = in_valid && in_ready;
      pop       = out_valid && out_ready;
      out_data  = entry_ff[rd_ptr_ff];
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= in_data;
      end
   end

   // Pointers and fill level.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
         end
         case ({push, pop})
            2'b10:   count_ff <= count_ff + CW'(1);
            2'b01:   count_ff <= count_ff - CW'(1);
            default: ;
         endcase
      end
   end

endmodule

### hw/rtl/orff_back.sv
// Back end: keeps the pending starts per frame and emits ORFs on stop codons.
module orff_back
   import orff_pkg::*;
#(
   parameter int PENDING_DEPTH  = 32,
   parameter int POSITION_WIDTH = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      cmd_valid,
   output logic                      cmd_ready,
   input  cmd_ctl_type               cmd_ctl,
   input  logic [POSITION_WIDTH-1:0] cmd_pos,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [31:0]               rsp_orf_start,
   output logic [31:0]               rsp_orf_end,
   output logic [1:0]                rsp_frame,
   output logic                      rsp_run_last,
   output logic                      rsp_starts_dropped
);

   localparam int KW        = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
   localparam int CW        = $clog2(PENDING_DEPTH + 1);
   localparam int AW        = KW + 2;
   localparam int MEM_DEPTH = FRAME_COUNT * (2 ** KW);

   back_state_type state_ff;
   back_state_type state_in;

   logic [POSITION_WIDTH-1:0] pend_mem [0:MEM_DEPTH-1];
   logic [POSITION_WIDTH-1:0] rd_data_ff;

   logic [CW-1:0]             count_ff [0:FRAME_COUNT-1];
   logic                      ovf_ff   [0:FRAME_COUNT-1];

   logic [1:0]                run_frame_ff;
   logic [POSITION_WIDTH-1:0] run_end_ff;
   logic [CW-1:0]             run_cnt_ff;
   logic                      run_ovf_ff;
   logic [KW-1:0]             k_ff;

   logic [31:0]               out_start_ff;
   logic [31:0]               out_end_ff;
   logic [1:0]                out_frame_ff;
   logic                      out_last_ff;
   logic                      out_dropped_ff;

   logic                      pop;
   logic                      is_start;
   logic                      is_stop;
   logic                      has_room;
   logic                      wr_en;
   logic                      rd_en;
   logic [AW-1:0]             wr_addr;
   logic [AW-1:0]             rd_addr;
   logic                      run_done;
   logic [POSITION_WIDTH+31:0] start_wide;
   logic [POSITION_WIDTH+31:0] end_wide;

   // Command decode and memory port control.
   always_comb begin
      cmd_ready = (state_ff == S_IDLE);
      pop       = cmd_valid && cmd_ready;
      is_start  = (cmd_ctl.kind == CMD_START);
      is_stop   = (cmd_ctl.kind == CMD_STOP);
      has_room  = (count_ff[cmd_ctl.frame] < CW'(PENDING_DEPTH));
      wr_en     = pop && is_start && has_room;
      wr_addr   = {cmd_ctl.frame, count_ff[cmd_ctl.frame][KW-1:0]};
      run_done  = ((CW + 1)'(k_ff) + (CW + 1)'(1)) == (CW + 1)'(run_cnt_ff);
      rd_en     = (pop && is_stop) || ((state_ff == S_SHOW) && rsp_ready && !out_last_ff);
      if (state_ff == S_IDLE) begin
         rd_addr = {cmd_ctl.frame, KW'(0)};
      end else begin
         rd_addr = {run_frame_ff, k_ff + KW'(1)};
      end
      start_wide = {32'd0, rd_data_ff};
      end_wide   = {32'd0, run_end_ff};
   end

   // Sequencer: a start or an empty stop is handled in S_IDLE; each ORF passes S_READ and S_SHOW.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (pop && is_stop && (count_ff[cmd_ctl.frame] != '0)) begin
               state_in = S_READ;
            end
         end
         S_READ: begin
            state_in = S_SHOW;
         end
         S_SHOW: begin
            if (rsp_ready) begin
               state_in = out_last_ff ? S_IDLE : S_READ;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Pending start storage with a registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         pend_mem[wr_addr] <= cmd_pos;
      end
      if (rd_en) begin
         rd_data_ff <= pend_mem[rd_addr];
      end
   end

   // Sequencer state, per-frame fill counts and overflow flags.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         for (int i = 0; i < FRAME_COUNT; i++) begin
            count_ff[i] <= '0;
            ovf_ff[i]   <= 1'b0;
         end
      end else begin
         state_ff <= state_in;
         if (pop) begin
            if (is_start) begin
               if (has_room) begin
                  count_ff[cmd_ctl.frame] <= count_ff[cmd_ctl.frame] + CW'(1);
               end else begin
                  ovf_ff[cmd_ctl.frame] <= 1'b1;
               end
            end else if (is_stop) begin
               count_ff[cmd_ctl.frame] <= '0;
               ovf_ff[cmd_ctl.frame]   <= 1'b0;
            end
            // The last base of a sequence drops every pending start.
            if (cmd_ctl.clear) begin
               for (int i = 0; i < FRAME_COUNT; i++) begin
                  count_ff[i] <= '0;
                  ovf_ff[i]   <= 1'b0;
               end
            end
         end
      end
   end

   // Run context captured whenever a stop is taken; the ORF index steps on each shown ORF.
   always_ff @(posedge clock) begin
      if (pop && is_stop) begin
         run_frame_ff <= cmd_ctl.frame;
         run_end_ff   <= cmd_pos;
         run_cnt_ff   <= count_ff[cmd_ctl.frame];
         run_ovf_ff   <= ovf_ff[cmd_ctl.frame];
         k_ff         <= '0;
      end else if ((state_ff == S_SHOW) && rsp_ready && !out_last_ff) begin
         k_ff <= k_ff + KW'(1);
      end
   end

   // Output register, loaded from the read data.
   always_ff @(posedge clock) begin
      if (state_ff == S_READ) begin
         out_start_ff   <= start_wide[31:0];
         out_end_ff     <= end_wide[31:0];
         out_frame_ff   <= run_frame_ff;
         out_last_ff    <= run_done;
         out_dropped_ff <= run_ovf_ff;
      end
   end

   always_comb begin
      rsp_valid          = (state_ff == S_SHOW);
      rsp_orf_start      = out_start_ff;
      rsp_orf_end        = out_end_ff;
      rsp_frame          = out_frame_ff;
      rsp_run_last       = out_last_ff;
      rsp_starts_dropped = out_dropped_ff;
   end

endmodule

### hw/rtl/open_reading_frame_finder.sv
// Top level of the three-frame open reading frame finder.
// One nucleotide transfer is taken per cycle as long as the four-entry command
// queue between the front end and the back end has room. The back end handles
// a start codon, and a stop codon with no pending start, in its idle state. A
// stop codon with pending starts is followed, for each ORF, by a read of the
// pending-start memory and the result transfer, which waits while the result
// side is not ready; the back end takes no new command until the last ORF has
// left. Each ORF passes the registered memory read and output register. ORFs
// leave in the order of their stop codons, oldest start first within one stop.
module open_reading_frame_finder
   import orff_pkg::*;
#(
   parameter int PENDING_DEPTH  = 32,
   parameter int POSITION_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_base,
   input  logic        req_last_base,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_orf_start,
   output logic [31:0] rsp_orf_end,
   output logic [1:0]  rsp_frame,
   output logic        rsp_run_last,
   output logic        rsp_starts_dropped,
   input  logic        csr_write_enable,
   input  logic        csr_index,
   input  logic [63:0] csr_write_data
);

   localparam int QW = $bits(cmd_ctl_type) + POSITION_WIDTH;

   logic                      fr_valid;
   logic                      fr_ready;
   cmd_ctl_type               fr_ctl;
   logic [POSITION_WIDTH-1:0] fr_pos;
   logic                      bk_valid;
   logic                      bk_ready;
   cmd_ctl_type               bk_ctl;
   logic [POSITION_WIDTH-1:0] bk_pos;
   logic [QW-1:0]             q_in;
   logic [QW-1:0]             q_out;

   assign q_in             = {fr_ctl, fr_pos};
   assign {bk_ctl, bk_pos} = q_out;

   orff_front #(
      .POSITION_WIDTH(POSITION_WIDTH)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_base        (req_base),
      .req_last_base   (req_last_base),
      .csr_write_enable(csr_write_enable),
      .csr_index       (csr_index),
      .csr_write_data  (csr_write_data),
      .cmd_valid       (fr_valid),
      .cmd_ready       (fr_ready),
      .cmd_ctl         (fr_ctl),
      .cmd_pos         (fr_pos)
   );

   orff_queue #(
      .WIDTH(QW)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .in_valid (fr_valid),
      .in_ready (fr_ready),
      .in_data  (q_in),
      .out_valid(bk_valid),
      .out_ready(bk_ready),
      .out_data (q_out)
   );

   orff_back #(
      .PENDING_DEPTH (PENDING_DEPTH),
      .POSITION_WIDTH(POSITION_WIDTH)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .cmd_valid         (bk_valid),
      .cmd_ready         (bk_ready),
      .cmd_ctl           (bk_ctl),
      .cmd_pos           (bk_pos),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_orf_start     (rsp_orf_start),
      .rsp_orf_end       (rsp_orf_end),
      .rsp_frame         (rsp_frame),
      .rsp_run_last      (rsp_run_last),
      .rsp_starts_dropped(rsp_starts_dropped)
   );

endmodule

### hw/rtl/orff_checker.sv
// Port-level checker of the open reading frame finder and its bind.
module orff_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_orf_start,
   input logic [31:0] rsp_orf_end,
   input logic [1:0]  rsp_frame,
   input logic        rsp_run_last,
   input logic        rsp_starts_dropped
);

   logic        in_run_ff;
   logic [31:0] prev_end_ff;
   logic [1:0]  prev_frame_ff;
   logic        prev_dropped_ff;

   // Track whether the last result transfer left a run of ORFs open.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_run_ff <= 1'b0;
      end else if (rsp_valid && rsp_ready) begin
         in_run_ff <= !rsp_run_last;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_valid && rsp_ready) begin
         prev_end_ff     <= rsp_orf_end;
         prev_frame_ff   <= rsp_frame;
         prev_dropped_ff <= rsp_starts_dropped;
      end
   end

   // No result is shown in the first cycle after reset is released.
   a_reset_quiet: assert property (@(posedge clock) !reset && $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   // A stalled result stays valid and holds its start, end, frame and last flag.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_orf_start)
         && $stable(rsp_orf_end) && $stable(rsp_frame) && $stable(rsp_run_last))
      else $error("stalled result changed");

   // All ORFs of one stop share the frame and the end position.
   a_run_same_stop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && in_run_ff |-> rsp_frame == prev_frame_ff
         && rsp_orf_end == prev_end_ff)
      else $error("ORF run changed stop codon before its last entry");

   // The dropped-starts flag is the same across one run.
   a_run_same_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && in_run_ff |-> rsp_starts_dropped == prev_dropped_ff)
      else $error("dropped-starts flag changed within an ORF run");

endmodule

bind open_reading_frame_finder orff_checker u_orff_checker (.*);

### dv/open_reading_frame_finder_tb.sv
// Self-checking testbench of the open reading frame finder: nucleotide stream in, ORF checks out.
module open_reading_frame_finder_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import orff_pkg::*;

   localparam int PEND_DEPTH   = 32;
   localparam int DRAIN_CYCLES = 40;
   localparam int MAX_REPORTS  = 10;

   // One open reading frame as the block reports it.
   typedef struct packed {
      logic [31:0] orf_start;
      logic [31:0] orf_end;
      logic [1:0]  frame;
      logic        run_last;
      logic        starts_dropped;
   } orf_type;

   // One nucleotide waiting to be sent.
   typedef struct {
      logic [1:0] base;
      logic       last;
      bit         drain_first;
   } nucleotide_type;

   logic        clock              = 1'b0;
   logic        reset              = 1'b1;
   logic        req_valid          = 1'b0;
   logic        req_ready;
   logic [1:0]  req_base           = 2'd0;
   logic        req_last_base      = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready          = 1'b0;
   logic [31:0] rsp_orf_start;
   logic [31:0] rsp_orf_end;
   logic [1:0]  rsp_frame;
   logic        rsp_run_last;
   logic        rsp_starts_dropped;
   logic        csr_write_enable   = 1'b0;
   logic        csr_index          = CSR_START_MASK;
   logic [63:0] csr_write_data     = 64'd0;

   open_reading_frame_finder #(
      .PENDING_DEPTH (PEND_DEPTH),
      .POSITION_WIDTH(32)
   ) dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_base          (req_base),
      .req_last_base     (req_last_base),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_orf_start     (rsp_orf_start),
      .rsp_orf_end       (rsp_orf_end),
      .rsp_frame         (rsp_frame),
      .rsp_run_last      (rsp_run_last),
      .rsp_starts_dropped(rsp_starts_dropped),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data)
   );

   // Free-running clock, 4 ns period.
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Predictor state: codon masks, base history and the open starts of each frame.
   logic [63:0] start_codons = START_MASK_RESET;
   logic [63:0] stop_codons  = STOP_MASK_RESET;
   logic [3:0]  hist_bases;
   logic [31:0] base_pos;
   int          base_frame;
   int          bases_seen;
   logic [31:0] open_starts [3][PEND_DEPTH];
   int          open_count [3];
   bit          lost_starts [3];
   orf_type     expected_orfs [$];

   // Stimulus storage and handshake bookkeeping.
   nucleotide_type base_items [$];
   logic [1:0]  seq_buf [$];
   int          next_item   = 0;
   int          drv_gap     = 0;
   int          drv_calm    = 0;
   int          mon_stall   = 0;
   int          mon_calm    = 0;
   int          mismatches  = 0;
   orf_type     got_orf;
   orf_type     want_orf;

   // Returns the predictor to the state after reset or after a last base.
   function automatic void clear_frames();
      hist_bases = 4'd0;
      base_pos   = 32'd0;
      base_frame = 0;
      bases_seen = 0;
      for (int f = 0; f < 3; f++) begin
         open_count[f]  = 0;
         lost_starts[f] = 1'b0;
      end
   endfunction

   // Advances the predictor by one base and queues the ORFs that it closes.
   function automatic void scan_base(input logic [1:0] b, input logic last);
      logic [5:0] codon;
      int         f;
      orf_type    orf;
      if (bases_seen >= 2) begin
         codon = {hist_bases, b};
         f = (base_frame + 1) % 3;
         if (start_codons[codon]) begin
            // A full frame drops the start and remembers the loss.
            if (open_count[f] < PEND_DEPTH) begin
               open_starts[f][open_count[f]] = base_pos - 32'd2;
               open_count[f]++;
            end else begin
               lost_starts[f] = 1'b1;
            end
         end else if (stop_codons[codon]) begin
            for (int k = 0; k < open_count[f]; k++) begin
               orf.orf_start      = open_starts[f][k];
               orf.orf_end        = base_pos;
               orf.frame          = 2'(f);
               orf.run_last       = (k == open_count[f] - 1);
               orf.starts_dropped = lost_starts[f];
               expected_orfs.insert(expected_orfs.size(), orf);
            end
            open_count[f]  = 0;
            lost_starts[f] = 1'b0;
         end
      end
      if (last) begin
         clear_frames();
      end else begin
         hist_bases = {hist_bases[1:0], b};
         base_pos   = base_pos + 32'd1;
         base_frame = (base_frame + 1) % 3;
         if (bases_seen < 2) bases_seen++;
      end
   endfunction

   // Idle length: mostly none or short, now and then long.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Driver: presents nucleotides with random idle gaps; a drain-first one waits for every ORF.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         drv_gap = 0;
      end else if (!req_valid || req_ready) begin
         if (drv_gap > 0) begin
            drv_gap--;
            req_valid <= 1'b0;
         end else if (next_item < base_items.size() &&
                      (!base_items[next_item].drain_first ||
                       (!req_valid && expected_orfs.size() == 0))) begin
            req_valid     <= 1'b1;
            req_base      <= base_items[next_item].base;
            req_last_base <= base_items[next_item].last;
            next_item++;
            if (drv_calm > 0) begin
               drv_calm--;
               drv_gap = 0;
            end else begin
               drv_gap = pick_gap();
               if ($urandom_range(0, 59) == 0) drv_calm = $urandom_range(30, 150);
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Monitor: checks each result transfer, then predicts from the input transfer.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         mon_stall = 0;
         clear_frames();
      end else begin
         if (rsp_valid && rsp_ready) begin
            got_orf = {rsp_orf_start, rsp_orf_end, rsp_frame, rsp_run_last, rsp_starts_dropped};
            if (expected_orfs.size() == 0) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("unexpected ORF: start %0d end %0d frame %0d last %0b dropped %0b",
                           got_orf.orf_start, got_orf.orf_end, got_orf.frame,
                           got_orf.run_last, got_orf.starts_dropped);
            end else begin
               want_orf = expected_orfs.pop_front();
               if (got_orf !== want_orf) begin
                  mismatches++;
                  // Fields in order: start, end, frame, last, dropped.
                  if (mismatches <= MAX_REPORTS)
                     $display("ORF mismatch: want %0d %0d %0d %0b %0b got %0d %0d %0d %0b %0b",
                              want_orf.orf_start, want_orf.orf_end, want_orf.frame,
                              want_orf.run_last, want_orf.starts_dropped,
                              got_orf.orf_start, got_orf.orf_end, got_orf.frame,
                              got_orf.run_last, got_orf.starts_dropped);
               end
            end
         end
         if (req_valid && req_ready) scan_base(req_base, req_last_base);

         // Random back pressure on the result channel.
         if (mon_stall > 0) begin
            mon_stall--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if (mon_calm > 0) begin
               mon_calm--;
            end else begin
               if ($urandom_range(0, 3) == 0) mon_stall = pick_gap();
               if ($urandom_range(0, 99) == 0) mon_calm = $urandom_range(30, 150);
            end
         end
      end
   end

   // Moves the scratch sequence into the send queue, last base flagged on its end.
   task automatic flush_seq(input bit drain);
      nucleotide_type item;
      for (int i = 0; i < seq_buf.size(); i++) begin
         item.base        = seq_buf[i];
         item.last        = (i == seq_buf.size() - 1);
         item.drain_first = drain && (i == 0);
         base_items.insert(base_items.size(), item);
      end
      seq_buf.delete();
   endtask

   // Appends one base to the scratch sequence.
   task automatic add_base(input logic [1:0] b);
      seq_buf.insert(seq_buf.size(), b);
   endtask

   // Queues a sequence written as letters.
   task automatic push_text(input string s, input bit drain);
      for (int i = 0; i < s.len(); i++) begin
         case (s[i])
            "C": add_base(2'd1);
            "G": add_base(2'd2);
            "T": add_base(2'd3);
            default: add_base(2'd0);
         endcase
      end
      flush_seq(drain);
   endtask

   // Picks a codon whose mask bit is set, or any codon if the mask is empty.
   function automatic logic [5:0] pick_codon(input logic [63:0] mask);
      int n;
      int k;
      n = $countones(mask);
      if (n == 0) return 6'($urandom_range(0, 63));
      k = $urandom_range(0, n - 1);
      for (int i = 0; i < 64; i++) begin
         if (mask[i]) begin
            if (k == 0) return 6'(i);
            k--;
         end
      end
      return 6'd0;
   endfunction

   task automatic push_codon(input logic [5:0] codon);
      add_base(codon[5:4]);
      add_base(codon[3:2]);
      add_base(codon[1:0]);
   endtask

   // More in-frame starts than a frame can hold, then two stops in that frame.
   task automatic push_flood();
      repeat ($urandom_range(33, 35)) push_codon(pick_codon(start_codons));
      push_codon(pick_codon(stop_codons));
      push_codon(pick_codon(stop_codons));
      repeat ($urandom_range(0, 5)) add_base(2'($urandom_range(0, 3)));
   endtask

   // Builds one random sequence: mostly codon-structured, some noise.
   task automatic gen_sequence(output int n);
      int r;
      int p;
      r = $urandom_range(0, 99);
      if (r < 8) begin
         repeat ($urandom_range(1, 12)) add_base(2'($urandom_range(0, 3)));
      end else if (r < 14) begin
         repeat ($urandom_range(1, 3)) add_base(2'($urandom_range(0, 3)));
      end else if (r < 18) begin
         push_flood();
      end else begin
         repeat ($urandom_range(4, 20)) begin
            p = $urandom_range(0, 99);
            if (p < 25) push_codon(pick_codon(start_codons));
            else if (p < 45) push_codon(pick_codon(stop_codons));
            else if (p < 55) add_base(2'($urandom_range(0, 3)));
            else push_codon(6'($urandom_range(0, 63)));
         end
      end
      n = seq_buf.size();
      flush_seq($urandom_range(0, 19) == 0);
   endtask

   task automatic gen_random(input int count);
      int total;
      int n;
      total = 0;
      while (total < count) begin
         gen_sequence(n);
         total += n;
      end
   endtask

   function automatic logic [63:0] rand_mask(input int nbits);
      logic [63:0] m;
      m = 64'd0;
      repeat (nbits) m[$urandom_range(0, 63)] = 1'b1;
      return m;
   endfunction

   // Waits until every nucleotide is sent and every ORF has arrived, then lets the block settle.
   task automatic settle();
      while (!(next_item == base_items.size() && !req_valid && expected_orfs.size() == 0))
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(input logic idx, input logic [63:0] value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      if (idx == CSR_START_MASK) start_codons = value;
      else stop_codons = value;
   endtask

   task automatic new_phase(input logic [63:0] start_mask, input logic [63:0] stop_mask);
      settle();
      write_csr(CSR_START_MASK, start_mask);
      write_csr(CSR_STOP_MASK, stop_mask);
      @(negedge clock);
   endtask

   // Stimulus: directed sequences, then random phases under several codon masks.
   initial begin
      logic [63:0] shared;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Single base, a start discarded by the last base, a two-base sequence.
      push_text("T", 1'b0);
      push_text("ATG", 1'b0);
      push_text("AG", 1'b0);
      // One ORF in frame 0, closed on the last base.
      push_text("ATGCCCTAA", 1'b0);
      // Stop with nothing pending in frame 2, two ORFs in frame 1; sent after a full drain.
      push_text("CATGATGTAGT", 1'b1);
      // Full frame: dropped starts are flagged, then a stop clears the flag.
      push_flood();
      flush_seq(1'b0);
      gen_random(15);

      new_phase(rand_mask(3), rand_mask(5));
      gen_random(15);

      // Extremes: no starts at all, every codon a stop.
      new_phase(64'd0, {64{1'b1}});
      gen_random(5);

      // Every codon a start and a stop: starts win.
      new_phase({64{1'b1}}, {64{1'b1}});
      gen_random(10);

      // Codons in both masks.
      shared = rand_mask(3);
      new_phase(shared, rand_mask(4) | shared);
      push_flood();
      flush_seq(1'b0);
      gen_random(10);

      new_phase(rand_mask(4), 64'd0);
      gen_random(5);

      // Back to the standard code.
      new_phase(START_MASK_RESET, STOP_MASK_RESET);
      gen_random(15);

      settle();
      if (mismatches == 0 && expected_orfs.size() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

   // Watchdog against a hung handshake.
   initial begin
      #20000000;
      $display("TB_ERROR");
      $finish;
   end

endmodule
